### design/blb_pkg.sv
`default_nettype none

package blb_pkg;

   // 15.16 fixed-point quantity, non-negative, 31 bits
   typedef logic [30:0] fx_type;

   localparam fx_type FX_MAX = 31'h7FFF_FFFF;

   // configuration register indexes
   localparam logic [1:0] CSR_HORIZONTAL_MODE = 2'd0;
   localparam logic [1:0] CSR_WRAP_ENABLE     = 2'd1;
   localparam logic [1:0] CSR_ROW_LIMIT       = 2'd2;
   localparam logic [1:0] CSR_COLUMN_LIMIT    = 2'd3;

   typedef struct packed {
      logic   horizontal_mode;
      logic   wrap_enable;
      fx_type row_limit;
      fx_type column_limit;
   } cfg_type;

   typedef struct packed {
      fx_type box_width;
      fx_type box_height;
      fx_type box_ascent;
      fx_type box_descent;
      logic   is_discardable;
      logic   is_last_box;
   } box_type;

   typedef struct packed {
      fx_type width;
      fx_type height;
      fx_type ascent;
      fx_type descent;
   } metrics_type;

   typedef struct packed {
      fx_type      line_width;
      fx_type      line_height;
      fx_type      line_ascent;
      fx_type      line_descent;
      logic [10:0] first_index;
      logic [10:0] box_count;
      logic        final_line;
   } line_type;

   function automatic fx_type sat_add(input fx_type a, input fx_type b);
      logic [31:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[31] ? FX_MAX : s[30:0];
   endfunction

endpackage

`default_nettype wire

### design/box_line_breaker.sv
`default_nettype none

// Greedy line breaker. Child boxes stream in one per transaction and are packed
// into rows (horizontal_mode 1) or columns (horizontal_mode 0); when wrap_enable
// is set, a box that would overflow row_limit or column_limit closes the open line.
// Each closed line leaves as one result transaction with its saturated metrics,
// first box index and box count; final_line (rsp_tlast) marks the line that ends
// a child list. A box waits in the input register while the step logic works on
// it, and the step fires only while the result queue has room; the lines that it
// closes then enter a three-entry result queue, whose head drives the result port.
// A box is accepted every cycle as long as results are
// taken; one box can close two lines (an overflow on the last box), and then the
// result queue, which must hold two free entries before the step logic fires,
// sets the pace. Box indexes and counts saturate at MAX_BOXES and are reported
// modulo 2048. Write the configuration only while no box is in flight.

module box_line_breaker
   import blb_pkg::*;
#(
   parameter int MAX_BOXES = 1024
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // box transactions
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // box_width, box_height, box_ascent, box_descent, zero pad
   input  wire logic [127:0] req_tdata,
   // is_discardable
   input  wire logic         req_tuser,
   input  wire logic         req_tlast,     // is_last_box
   // line transactions
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // line_width, line_height, line_ascent, line_descent, first_index, box_count,
   // zero pad
   output logic [151:0]      rsp_tdata,
   output logic              rsp_tlast,     // final_line
   // configuration writes
   input  wire logic         csr_wen,
   input  wire logic [1:0]   csr_index,
   input  wire logic [30:0]  csr_wdata
);

   localparam int CW = $clog2(MAX_BOXES + 1);
   localparam logic [CW-1:0] MAX_IDX = CW'(MAX_BOXES);

   // configuration
   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.horizontal_mode <= 1'b1;
         cfg_ff.wrap_enable     <= 1'b0;
         cfg_ff.row_limit       <= '0;
         cfg_ff.column_limit    <= '0;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_HORIZONTAL_MODE: cfg_ff.horizontal_mode <= csr_wdata[0];
            CSR_WRAP_ENABLE:     cfg_ff.wrap_enable     <= csr_wdata[0];
            CSR_ROW_LIMIT:       cfg_ff.row_limit       <= csr_wdata;
            CSR_COLUMN_LIMIT:    cfg_ff.column_limit    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // input register: hold the box until the step logic can fire
   logic    s1_valid_ff;
   box_type s1_box_ff;
   box_type s1_box_in;
   logic    go;
   logic    room;

   assign go         = s1_valid_ff && room;
   assign req_tready = !s1_valid_ff || go;

   assign s1_box_in.box_width      = req_tdata[30:0];
   assign s1_box_in.box_height     = req_tdata[61:31];
   assign s1_box_in.box_ascent     = req_tdata[92:62];
   assign s1_box_in.box_descent    = req_tdata[123:93];
   assign s1_box_in.is_discardable = req_tuser;
   assign s1_box_in.is_last_box    = req_tlast;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) s1_box_ff <= s1_box_in;
   end

   // open-line state
   metrics_type   met_ff;
   metrics_type   met_in;
   fx_type        pend_ff;
   fx_type        pend_in;
   logic          pend_valid_ff;
   logic          pend_valid_in;
   logic [CW-1:0] start_ff;
   logic [CW-1:0] start_in;
   logic [CW-1:0] members_ff;
   logic [CW-1:0] members_in;
   logic [CW-1:0] box_idx_ff;
   logic [CW-1:0] box_idx_in;
   logic          res_a_valid;
   logic          res_b_valid;
   line_type      res_a;
   line_type      res_b;

   blb_step #(
      .MAX_BOXES (MAX_BOXES)
   ) u_step (
      .cfg            (cfg_ff),
      .box            (s1_box_ff),
      .met_cur        (met_ff),
      .pend_cur       (pend_ff),
      .pend_valid_cur (pend_valid_ff),
      .start_cur      (start_ff),
      .members_cur    (members_ff),
      .index_cur      (box_idx_ff),
      .met_nxt        (met_in),
      .pend_nxt       (pend_in),
      .pend_valid_nxt (pend_valid_in),
      .start_nxt      (start_in),
      .members_nxt    (members_in),
      .index_nxt      (box_idx_in),
      .res_a_valid    (res_a_valid),
      .res_a          (res_a),
      .res_b_valid    (res_b_valid),
      .res_b          (res_b)
   );

   // advance the line state only when the step fires
   always_ff @(posedge clock) begin
      if (reset) begin
         met_ff        <= '0;
         pend_ff       <= '0;
         pend_valid_ff <= 1'b0;
         start_ff      <= '0;
         members_ff    <= '0;
         box_idx_ff    <= '0;
      end else if (go) begin
         met_ff        <= met_in;
         pend_ff       <= pend_in;
         pend_valid_ff <= pend_valid_in;
         start_ff      <= start_in;
         members_ff    <= members_in;
         box_idx_ff    <= box_idx_in;
      end
   end

   // result queue
   line_type head;
   logic     head_valid;

   blb_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push_a     (go && res_a_valid),
      .data_a     (res_a),
      .push_b     (go && res_b_valid),
      .data_b     (res_b),
      .pop        (head_valid && rsp_tready),
      .head_valid (head_valid),
      .head       (head),
      .room       (room)
   );

   assign rsp_tvalid = head_valid;
   assign rsp_tlast  = head.final_line;
   assign rsp_tdata  = {6'b0, head.box_count, head.first_index, head.line_descent,
                        head.line_ascent, head.line_height, head.line_width};

   // a box that ends the child list returns the index counter to zero
   a_last_clears_index : assert property (@(posedge clock) disable iff (reset)
      go && s1_box_ff.is_last_box |=> box_idx_ff == '0)
      else $error("box index not cleared after last box");

   // counters never pass their saturation point
   a_counters_saturate : assert property (@(posedge clock) disable iff (reset)
      box_idx_ff <= MAX_IDX && members_ff <= MAX_IDX && start_ff <= MAX_IDX)
      else $error("box counter beyond MAX_BOXES");

   // a second result only comes with a first one in the same step
   a_second_needs_first : assert property (@(posedge clock) disable iff (reset)
      go && res_b_valid |-> res_a_valid && res_b.final_line)
      else $error("second result without first or not final");

endmodule

`default_nettype wire

### design/blb_step.sv
`default_nettype none

module blb_step
   import blb_pkg::*;
#(
   parameter int MAX_BOXES = 1024,
   localparam int CW = $clog2(MAX_BOXES + 1)
) (
   input  cfg_type          cfg,
   input  box_type          box,
   input  metrics_type      met_cur,
   input  fx_type           pend_cur,
   input  logic             pend_valid_cur,
   input  logic [CW-1:0]    start_cur,
   input  logic [CW-1:0]    members_cur,
   input  logic [CW-1:0]    index_cur,
   output metrics_type      met_nxt,
   output fx_type           pend_nxt,
   output logic             pend_valid_nxt,
   output logic [CW-1:0]    start_nxt,
   output logic [CW-1:0]    members_nxt,
   output logic [CW-1:0]    index_nxt,
   output logic             res_a_valid,
   output line_type         res_a,
   output logic             res_b_valid,
   output line_type         res_b
);

   localparam logic [CW-1:0] MAX_IDX = CW'(MAX_BOXES);

   function automatic logic [CW-1:0] bump(input logic [CW-1:0] v);
      return (v < MAX_IDX) ? v + 1'b1 : MAX_IDX;
   endfunction

   function automatic logic [10:0] idx11(input logic [CW-1:0] v);
      logic [CW+10:0] e;
      e = {11'b0, v};
      return e[10:0];
   endfunction

   function automatic line_type make_line(input metrics_type m, input logic [CW-1:0] st,
                                          input logic [CW-1:0] mb, input logic fin);
      line_type l;
      l.line_width   = m.width;
      l.line_height  = m.height;
      l.line_ascent  = m.ascent;
      l.line_descent = m.descent;
      l.first_index  = idx11(st);
      l.box_count    = idx11(mb);
      l.final_line   = fin;
      return l;
   endfunction

   always_comb begin
      metrics_type   m;
      fx_type        pd;
      logic          pv;
      logic [CW-1:0] st;
      logic [CW-1:0] mb;
      logic [CW-1:0] ix;
      logic          brk;
      logic          done;
      fx_type        ad;
      line_type      brk_line;
      line_type      last_line;

      m         = met_cur;
      pd        = pend_cur;
      pv        = pend_valid_cur;
      st        = start_cur;
      mb        = members_cur;
      ix        = index_cur;
      done      = 1'b0;
      ad        = '0;
      brk_line  = '0;
      last_line = '0;

      if (!cfg.horizontal_mode) begin
         brk = cfg.wrap_enable &&
               (({1'b0, box.box_height} + {1'b0, m.height}) > {1'b0, cfg.column_limit});
         if (brk) begin
            brk_line = make_line(m, st, mb, 1'b0);
            m  = '0;
            st = ix;
            mb = '0;
            pd = '0;
            pv = 1'b0;
         end
         if (box.box_width > m.width) m.width = box.box_width;
         m.height = sat_add(m.height, box.box_height);
         mb       = bump(mb);
      end else begin
         brk = cfg.wrap_enable && (ix != '0) &&
               (({1'b0, box.box_width} + {1'b0, m.width}) > {1'b0, cfg.row_limit});
         if (brk) begin
            // a row without text takes its height as ascent
            if (m.ascent == '0) begin
               m.ascent  = m.height;
               m.descent = '0;
            end
            // drop a trailing space from the closed row
            if (pv) begin
               m.width = (m.width > pd) ? m.width - pd : '0;
               if (mb != '0) mb = mb - 1'b1;
            end
            brk_line = make_line(m, st, mb, box.is_discardable && box.is_last_box);
            m  = '0;
            st = ix;
            mb = '0;
            pd = '0;
            pv = 1'b0;
            if (box.is_discardable) begin
               done = 1'b1;
               if (box.is_last_box) begin
                  st = '0;
                  ix = '0;
               end else begin
                  st = bump(ix);
                  ix = bump(ix);
               end
            end
         end
         if (!done) begin
            if (box.box_ascent != '0) begin
               if (m.ascent < box.box_ascent) m.ascent = box.box_ascent;
               if (m.descent < box.box_descent) m.descent = box.box_descent;
               ad = sat_add(m.ascent, m.descent);
               if (m.height < ad) m.height = ad;
            end else if (box.box_height > m.height) begin
               m.height = box.box_height;
            end
            m.width = sat_add(m.width, box.box_width);
            mb      = bump(mb);
            pv      = box.is_discardable;
            pd      = box.is_discardable ? box.box_width : '0;
         end
      end

      if (!done) begin
         ix = bump(ix);
         if (box.is_last_box) begin
            last_line = make_line(m, st, mb, 1'b1);
            m  = '0;
            st = '0;
            mb = '0;
            pd = '0;
            pv = 1'b0;
            ix = '0;
         end
      end

      met_nxt        = m;
      pend_nxt       = pd;
      pend_valid_nxt = pv;
      start_nxt      = st;
      members_nxt    = mb;
      index_nxt      = ix;
      res_a_valid    = brk || (!done && box.is_last_box);
      res_a          = brk ? brk_line : last_line;
      res_b_valid    = brk && !done && box.is_last_box;
      res_b          = last_line;
   end

endmodule

`default_nettype wire

### design/blb_rsp_queue.sv
`default_nettype none

module blb_rsp_queue
   import blb_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push_a,
   input  line_type data_a,
   input  logic     push_b,
   input  line_type data_b,
   input  logic     pop,
   output logic     head_valid,
   output line_type head,
   output logic     room
);

   localparam int DEPTH = 3;

   line_type   q_ff [DEPTH];
   line_type   q_in [DEPTH];
   logic [1:0] cnt_ff;
   logic [1:0] cnt_in;
   logic [1:0] cnt_p;

   assign head_valid = (cnt_ff != 2'd0);
   assign head       = q_ff[0];
   // two free entries are needed for an item that closes two lines
   assign room       = (cnt_ff <= 2'd1);

   always_comb begin
      cnt_p = cnt_ff - {1'b0, pop};
      for (int i = 0; i < DEPTH; i++) begin
         if (pop && i < DEPTH - 1) q_in[i] = q_ff[i + 1];
         else                      q_in[i] = q_ff[i];
         if (push_a && cnt_p == 2'(i)) q_in[i] = data_a;
         if (push_b && 2'(cnt_p + 2'd1) == 2'(i)) q_in[i] = data_b;
      end
      cnt_in = cnt_p + {1'b0, push_a} + {1'b0, push_b};
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) q_ff[i] <= q_in[i];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

endmodule

`default_nettype wire
